// ===== hdl/stl_pkg.sv =====
`default_nettype none

package stl_pkg;

    localparam int ID_W   = 31;
    localparam int SLOT_W = 6;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_CLEAR       = 3'd0,
        CMD_INSERT      = 3'd1,
        CMD_FIND_ID     = 3'd2,
        CMD_FIND_AUTHOR = 3'd3,
        CMD_DELETE      = 3'd4,
        CMD_SET_AUTHOR  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]      command;
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] new_author;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   entry_id;
        logic [ID_W-1:0]   entry_author;
    } t_out;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] author;
    } t_entry;

    typedef struct packed {
        logic            en;
        stl_pkg::t_entry data;
    } t_wr_ctl;

endpackage

`default_nettype wire

// ===== hdl/slot_table_with_id_lookup_top.sv =====
// from acceptance to o_out_valid: clear runs the whole sweep, delete scans every slot,
// an undefined command goes straight to the result; insert, find and set author stop
// at the first hit or at the table's end, one slot compared per cycle through one read port
// throughput: one command at a time, ready low until its result is registered
// reset: a clearing sweep marks every slot empty, ready low meanwhile
// reset also sets id_start and the id counter to zero; config writes are taken always
`default_nettype none

module slot_table_with_id_lookup_top #(
    parameter int SLOTS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,

    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire stl_pkg::t_in  i_in,

    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output stl_pkg::t_out      o_out,

    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = stl_pkg::ID_W;
    localparam int SW = stl_pkg::SLOT_W;

    stl_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_chk_addr, n_chk_addr;
    logic            r_chk_vld, n_chk_vld;
    logic            r_found, n_found;
    logic            r_clr_reply, n_clr_reply;
    logic [2:0]      r_cmd, n_cmd;
    logic [IW-1:0]   r_key, n_key;
    logic [IW-1:0]   r_new_author, n_new_author;
    logic [IW-1:0]   r_id_start;
    logic [IW-1:0]   r_id_counter, n_id_counter;
    stl_pkg::t_out   r_res, n_res;
    stl_pkg::t_out   r_out, n_out;
    logic            r_out_valid, n_out_valid;

    stl_pkg::t_wr_ctl wr;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    stl_pkg::t_entry  rd_data;

    logic [IW-1:0] cmp_field;
    logic          hit;
    logic [IW-1:0] id_next;

    stl_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {1'b0, r_id_start} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_start <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_id_start <= pwdata[IW-1:0];
        end
    end

    // the shared compare: id or author of the slot just read against the key
    assign cmp_field = (r_cmd == stl_pkg::CMD_FIND_AUTHOR) ? rd_data.author : rd_data.id;
    assign hit       = (r_cmd == stl_pkg::CMD_INSERT) ? !rd_data.valid
                                                      : (rd_data.valid && (cmp_field == r_key));
    assign id_next   = r_id_counter + 1'b1;

    assign o_in_ready  = (r_state == stl_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stl_pkg::S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_chk_addr   = r_chk_addr;
        n_chk_vld    = 1'b0;
        n_found      = r_found;
        n_clr_reply  = r_clr_reply;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_new_author = r_new_author;
        n_id_counter = r_id_counter;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        wr           = '0;
        wr_addr      = r_chk_addr;
        rd_en        = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            stl_pkg::S_SWEEP: begin
                wr.en   = 1'b1;
                wr_addr = r_addr[AW-1:0];
                n_addr  = r_addr + 1'b1;
                if (r_addr == CW'(SLOTS - 1)) begin
                    n_state = r_clr_reply ? stl_pkg::S_DONE : stl_pkg::S_IDLE;
                end
            end

            stl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_in.command;
                    n_key        = i_in.key;
                    n_new_author = i_in.new_author;
                    n_addr       = '0;
                    n_found      = 1'b0;
                    n_res        = '0;
                    case (i_in.command)
                        stl_pkg::CMD_CLEAR: begin
                            n_id_counter = r_id_start;
                            n_clr_reply  = 1'b1;
                            n_res.status = stl_pkg::ST_OK;
                            n_state      = stl_pkg::S_SWEEP;
                        end
                        stl_pkg::CMD_INSERT, stl_pkg::CMD_FIND_ID, stl_pkg::CMD_FIND_AUTHOR,
                        stl_pkg::CMD_DELETE, stl_pkg::CMD_SET_AUTHOR: begin
                            n_state = stl_pkg::S_SCAN;
                        end
                        default: begin
                            n_res.status = stl_pkg::ST_NOT_FOUND;
                            n_state      = stl_pkg::S_DONE;
                        end
                    endcase
                end
            end

            stl_pkg::S_SCAN: begin
                // read one slot ahead while the previous one is compared
                if (r_addr < CW'(SLOTS)) begin
                    rd_en      = 1'b1;
                    n_chk_vld  = 1'b1;
                    n_chk_addr = r_addr[AW-1:0];
                    n_addr     = r_addr + 1'b1;
                end

                if (r_chk_vld && hit) begin
                    case (r_cmd)
                        stl_pkg::CMD_INSERT: begin
                            n_state = stl_pkg::S_DONE;
                            if (r_id_counter == stl_pkg::ID_MAX) begin
                                n_res.status = stl_pkg::ST_EXHAUSTED;
                            end else begin
                                n_id_counter       = id_next;
                                wr.en              = 1'b1;
                                wr.data.valid      = 1'b1;
                                wr.data.id         = id_next;
                                n_res.status       = stl_pkg::ST_OK;
                                n_res.slot         = SW'(r_chk_addr);
                                n_res.entry_id     = id_next;
                                n_res.entry_author = '0;
                            end
                        end
                        stl_pkg::CMD_SET_AUTHOR: begin
                            wr.en              = 1'b1;
                            wr.data.valid      = 1'b1;
                            wr.data.id         = rd_data.id;
                            wr.data.author     = r_new_author;
                            n_res.status       = stl_pkg::ST_OK;
                            n_res.slot         = SW'(r_chk_addr);
                            n_res.entry_id     = rd_data.id;
                            n_res.entry_author = r_new_author;
                            n_state            = stl_pkg::S_DONE;
                        end
                        stl_pkg::CMD_DELETE: begin
                            // every matching slot goes, the lowest one is reported
                            wr.en = 1'b1;
                            if (!r_found) begin
                                n_found            = 1'b1;
                                n_res.status       = stl_pkg::ST_OK;
                                n_res.slot         = SW'(r_chk_addr);
                                n_res.entry_id     = rd_data.id;
                                n_res.entry_author = rd_data.author;
                            end
                        end
                        default: begin
                            n_res.status       = stl_pkg::ST_OK;
                            n_res.slot         = SW'(r_chk_addr);
                            n_res.entry_id     = rd_data.id;
                            n_res.entry_author = rd_data.author;
                            n_state            = stl_pkg::S_DONE;
                        end
                    endcase
                end else if (!r_chk_vld && (r_addr == CW'(SLOTS))) begin
                    // scan ran off the end
                    n_state = stl_pkg::S_DONE;
                    if (r_cmd == stl_pkg::CMD_INSERT) begin
                        n_res.status = stl_pkg::ST_FULL;
                    end else if (!r_found) begin
                        n_res.status = stl_pkg::ST_NOT_FOUND;
                    end
                end
            end

            stl_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_clr_reply = 1'b0;
                    n_state     = stl_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = stl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_chk_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_clr_reply  <= 1'b0;
            r_id_counter <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_addr       <= n_addr;
            r_chk_vld    <= n_chk_vld;
            r_found      <= n_found;
            r_clr_reply  <= n_clr_reply;
            r_id_counter <= n_id_counter;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr   <= n_chk_addr;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_new_author <= n_new_author;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stl_pkg::S_SCAN) |-> (r_addr <= CW'(SLOTS)))
        else $error("scan address past the table");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second command taken while one is in progress");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != stl_pkg::ST_OK)) |->
        ((o_out.slot == '0) && (o_out.entry_id == '0) && (o_out.entry_author == '0)))
        else $error("failed command reports slot data");

    a_sweep_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stl_pkg::S_SWEEP) |-> (wr.en && !rd_en && !o_in_ready))
        else $error("clearing sweep not exclusive");

endmodule

`default_nettype wire

// ===== hdl/stl_ram.sv =====
`default_nettype none

module stl_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            i_clk,
    input  wire stl_pkg::t_wr_ctl i_wr,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output stl_pkg::t_entry      o_rd_data
);

    stl_pkg::t_entry r_mem [DEPTH];
    stl_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== dv/slot_table_with_id_lookup_top_tb.sv =====
`timescale 1ns / 1ps

module slot_table_with_id_lookup_top_tb;

    localparam int SLOTS = 64;
    localparam int RUN_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 310;
    localparam int ID_W = stl_pkg::ID_W;
    localparam int SLOT_W = stl_pkg::SLOT_W;

    localparam logic [2:0] ADDR_ID_START = 3'd0;
    localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
    localparam logic [2:0] CMD_UNDEF_7 = 3'd7;

    typedef struct {
        stl_pkg::t_in  item;
        bit            typed;
        stl_pkg::t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    stl_pkg::t_in  in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    stl_pkg::t_out out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // model of the table
    bit              tbl_valid [SLOTS];
    logic [ID_W-1:0] tbl_id [SLOTS];
    logic [ID_W-1:0] tbl_author [SLOTS];
    logic [ID_W-1:0] id_ctr;
    logic [ID_W-1:0] cfg_id_start;

    stl_pkg::t_out results_due [$];
    t_row dir_rows [$];
    int   err_cnt = 0;
    int   items_accepted = 0;
    int   run_cycles = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    bit   steady_run = 1'b0;

    slot_table_with_id_lookup_top #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        run_cycles++;
        if (run_cycles >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     run_cycles, results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < 200)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic logic [ID_W-1:0] rand_word();
        logic [31:0] w;
        w = $urandom();
        return w[ID_W-1:0];
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_author[i] = '0;
        end
        id_ctr = cfg_id_start;
    endfunction

    function automatic int lowest_match(input logic [ID_W-1:0] key, input bit by_author);
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && (by_author ? tbl_author[i] : tbl_id[i]) == key)
                return i;
        end
        return -1;
    endfunction

    function automatic stl_pkg::t_out slot_result(input int hit);
        stl_pkg::t_out res;
        res.status = stl_pkg::ST_OK;
        res.slot = hit[SLOT_W-1:0];
        res.entry_id = tbl_id[hit];
        res.entry_author = tbl_author[hit];
        return res;
    endfunction

    // applies one command to the model and returns the result it gives
    function automatic stl_pkg::t_out table_step(input stl_pkg::t_in item);
        stl_pkg::t_out res;
        int hit;
        res = '0;
        res.status = stl_pkg::ST_NOT_FOUND;
        hit = -1;
        case (item.command)
            stl_pkg::CMD_CLEAR: begin
                wipe_table();
                res.status = stl_pkg::ST_OK;
            end
            stl_pkg::CMD_INSERT: begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!tbl_valid[i])
                        hit = i;
                end
                // full is checked ahead of the counter
                if (hit < 0) begin
                    res.status = stl_pkg::ST_FULL;
                end else if (id_ctr == stl_pkg::ID_MAX) begin
                    res.status = stl_pkg::ST_EXHAUSTED;
                end else begin
                    id_ctr++;
                    tbl_valid[hit] = 1'b1;
                    tbl_id[hit] = id_ctr;
                    tbl_author[hit] = '0;
                    res = slot_result(hit);
                end
            end
            stl_pkg::CMD_FIND_ID, stl_pkg::CMD_FIND_AUTHOR: begin
                hit = lowest_match(item.key, item.command == stl_pkg::CMD_FIND_AUTHOR);
                if (hit >= 0)
                    res = slot_result(hit);
            end
            stl_pkg::CMD_DELETE: begin
                hit = lowest_match(item.key, 1'b0);
                if (hit >= 0) begin
                    // reports the entry as it was before removal
                    res = slot_result(hit);
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_valid[i] && tbl_id[i] == item.key) begin
                            tbl_valid[i] = 1'b0;
                            tbl_id[i] = '0;
                            tbl_author[i] = '0;
                        end
                    end
                end
            end
            stl_pkg::CMD_SET_AUTHOR: begin
                hit = lowest_match(item.key, 1'b0);
                if (hit >= 0) begin
                    tbl_author[hit] = item.new_author;
                    res = slot_result(hit);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // id or author of a random occupied slot, small value if the table is empty
    function automatic logic [ID_W-1:0] live_key(input bit want_author);
        int live [$];
        int pick;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i])
                live.push_back(i);
        end
        if (live.size() == 0)
            return ID_W'($urandom_range(0, 70));
        pick = live[$urandom_range(0, live.size() - 1)];
        return want_author ? tbl_author[pick] : tbl_id[pick];
    endfunction

    task automatic send_cmd(input stl_pkg::t_in item, input bit typed,
                            input stl_pkg::t_out want);
        stl_pkg::t_out pred;
        while (!steady_run && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (!in_ready);
        pred = table_step(item);
        results_due.push_back(typed ? want : pred);
        items_accepted++;
    endtask

    task automatic send_plain(input logic [2:0] cmd, input logic [ID_W-1:0] key,
                              input logic [ID_W-1:0] new_author);
        stl_pkg::t_in item;
        item.command = cmd;
        item.key = key;
        item.new_author = new_author;
        send_cmd(item, 1'b0, '0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_id_start(input logic [ID_W-1:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ID_START;
        pwdata <= {1'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_id_start = value;
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [ID_W-1:0] key,
                           input logic [ID_W-1:0] new_author, input bit typed,
                           input stl_pkg::t_status st = stl_pkg::ST_OK, input int sl = 0,
                           input logic [ID_W-1:0] id = '0,
                           input logic [ID_W-1:0] author = '0);
        t_row r;
        r.item.command = cmd;
        r.item.key = key;
        r.item.new_author = new_author;
        r.typed = typed;
        r.want.status = st;
        r.want.slot = sl[SLOT_W-1:0];
        r.want.entry_id = id;
        r.want.entry_author = author;
        dir_rows.push_back(r);
    endtask

    task automatic random_cmd();
        int pick;
        logic [ID_W-1:0] key;
        pick = $urandom_range(99);
        if (pick < 28) begin
            send_plain(stl_pkg::CMD_INSERT, rand_word(), rand_word());
        end else if (pick < 42) begin
            send_plain(stl_pkg::CMD_FIND_ID, live_key(1'b0), rand_word());
        end else if (pick < 52) begin
            send_plain(stl_pkg::CMD_FIND_AUTHOR, live_key(1'b1), rand_word());
        end else if (pick < 63) begin
            send_plain(stl_pkg::CMD_DELETE, live_key(1'b0), rand_word());
        end else if (pick < 76) begin
            // a small pool of author codes makes shared authors common
            send_plain(stl_pkg::CMD_SET_AUTHOR, live_key(1'b0),
                       $urandom_range(1) ? ID_W'($urandom_range(0, 3)) : rand_word());
        end else if (pick < 78) begin
            send_plain(stl_pkg::CMD_CLEAR, rand_word(), rand_word());
        end else begin
            case ($urandom_range(3))
                0: key = live_key(1'($urandom_range(1)));
                1: key = ID_W'($urandom_range(0, 70));
                2: key = rand_word();
                default: key = stl_pkg::ID_MAX;
            endcase
            send_plain(3'($urandom_range(7)), key, rand_word());
        end
    endtask

    // receiving side: checks each beat and drives ready
    always @(posedge i_clk) begin : rx_side
        stl_pkg::t_out due;
        if (i_rst_n && out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing due: %p", out_data));
            end else begin
                due = results_due.pop_front();
                if (out_data.status !== due.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_data.status, due.status));
                if (out_data.slot !== due.slot)
                    report_mismatch($sformatf("slot %0d, want %0d",
                                              out_data.slot, due.slot));
                if (out_data.entry_id !== due.entry_id)
                    report_mismatch($sformatf("entry_id %h, want %h",
                                              out_data.entry_id, due.entry_id));
                if (out_data.entry_author !== due.entry_author)
                    report_mismatch($sformatf("entry_author %h, want %h",
                                              out_data.entry_author, due.entry_author));
            end
        end
        out_ready <= (hold_left == 0) && (steady_run || $urandom_range(99) >= 35);
    end

    // one long hold-off on the result side while commands keep coming
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && items_accepted >= 600) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [ID_W-1:0] phase_start [6];
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_id_start = '0;
        wipe_table();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_id_start('0);

        // empty table: nothing matches, not even id 0
        add_row(stl_pkg::CMD_FIND_ID, '0, '0, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(stl_pkg::CMD_FIND_AUTHOR, '0, '0, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(stl_pkg::CMD_DELETE, '0, '0, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(stl_pkg::CMD_SET_AUTHOR, '0, stl_pkg::ID_MAX, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(CMD_UNDEF_6, stl_pkg::ID_MAX, stl_pkg::ID_MAX, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(CMD_UNDEF_7, '0, '0, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(stl_pkg::CMD_INSERT, stl_pkg::ID_MAX, stl_pkg::ID_MAX, 1'b1,
                stl_pkg::ST_OK, 0, ID_W'(1), '0);
        add_row(stl_pkg::CMD_INSERT, '0, '0, 1'b1, stl_pkg::ST_OK, 1, ID_W'(2), '0);
        add_row(stl_pkg::CMD_SET_AUTHOR, ID_W'(1), stl_pkg::ID_MAX, 1'b1,
                stl_pkg::ST_OK, 0, ID_W'(1), stl_pkg::ID_MAX);
        add_row(stl_pkg::CMD_FIND_AUTHOR, stl_pkg::ID_MAX, '0, 1'b1,
                stl_pkg::ST_OK, 0, ID_W'(1), stl_pkg::ID_MAX);
        add_row(stl_pkg::CMD_FIND_ID, ID_W'(2), '0, 1'b1, stl_pkg::ST_OK, 1, ID_W'(2), '0);
        add_row(stl_pkg::CMD_FIND_AUTHOR, '0, stl_pkg::ID_MAX, 1'b1,
                stl_pkg::ST_OK, 1, ID_W'(2), '0);
        add_row(stl_pkg::CMD_DELETE, ID_W'(1), '0, 1'b1,
                stl_pkg::ST_OK, 0, ID_W'(1), stl_pkg::ID_MAX);
        add_row(stl_pkg::CMD_FIND_ID, ID_W'(1), '0, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(stl_pkg::CMD_INSERT, '0, '0, 1'b0);
        add_row(stl_pkg::CMD_FIND_ID, stl_pkg::ID_MAX, '0, 1'b1, stl_pkg::ST_NOT_FOUND);
        add_row(stl_pkg::CMD_SET_AUTHOR, ID_W'(3), 31'h2AAA_AAAA, 1'b0);
        add_row(stl_pkg::CMD_CLEAR, stl_pkg::ID_MAX, stl_pkg::ID_MAX, 1'b1, stl_pkg::ST_OK);
        add_row(stl_pkg::CMD_FIND_ID, ID_W'(3), '0, 1'b1, stl_pkg::ST_NOT_FOUND);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // counter runs out two inserts after the clear
        write_id_start(stl_pkg::ID_MAX - ID_W'(2));
        send_plain(stl_pkg::CMD_CLEAR, '0, '0);
        repeat (4) send_plain(stl_pkg::CMD_INSERT, rand_word(), rand_word());

        write_id_start(stl_pkg::ID_MAX);
        send_plain(stl_pkg::CMD_CLEAR, '0, '0);
        send_plain(stl_pkg::CMD_INSERT, '0, '0);

        // the table fills exactly as the counter saturates: full wins
        write_id_start(stl_pkg::ID_MAX - ID_W'(SLOTS));
        send_plain(stl_pkg::CMD_CLEAR, '0, '0);
        repeat (SLOTS + 1) send_plain(stl_pkg::CMD_INSERT, rand_word(), rand_word());
        send_plain(stl_pkg::CMD_FIND_ID, stl_pkg::ID_MAX, '0);
        send_plain(stl_pkg::CMD_DELETE, stl_pkg::ID_MAX, '0);
        send_plain(stl_pkg::CMD_INSERT, '0, '0);

        phase_start[0] = rand_word();
        phase_start[1] = '0;
        phase_start[2] = stl_pkg::ID_MAX - ID_W'(40);
        phase_start[3] = ID_W'(1);
        phase_start[4] = rand_word();
        phase_start[5] = stl_pkg::ID_MAX - ID_W'(5);

        for (int p = 0; p < 6; p++) begin
            write_id_start(phase_start[p]);
            steady_run = (p == 3);
            send_plain(stl_pkg::CMD_CLEAR, rand_word(), rand_word());
            repeat (PHASE_ITEMS - 1) random_cmd();
        end
        steady_run = 1'b0;

        drain();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/stl_pkg.sv
hdl/stl_ram.sv
hdl/slot_table_with_id_lookup_top.sv
dv/slot_table_with_id_lookup_top_tb.sv
